FILE: rtl/button_click_classifier_unit_macros.svh
// Assertion macros shared by the button click classifier checker.
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH

// Check a property at each rising clock edge outside reset.
`define BCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define BCC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bcc_pkg.sv
// Shared types and constants of the button click classifier.
package bcc_pkg;

    localparam int CNT_W      = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CNT_W-1:0] WINDOW_RST   = 16'd200;
    localparam logic [CNT_W-1:0] HOLD_RST     = 16'd50;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_WINDOW   = 2'd1,
        REG_HOLD     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] debounce;
        logic [CNT_W-1:0] window;
        logic [CNT_W-1:0] hold;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic stop;
    } t_tmr_cmd;

    typedef struct packed {
        logic press;
        logic dbl;
        logic single;
    } t_events;

endpackage

FILE: rtl/bcc_regs.sv
// APB configuration registers of the button click classifier.
module bcc_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bcc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bcc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bcc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output bcc_pkg::t_cfg                   o_cfg
);
    import bcc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_DEBOUNCE: n_cfg.debounce = pwdata[CNT_W-1:0];
                REG_WINDOW:   n_cfg.window   = pwdata[CNT_W-1:0];
                REG_HOLD:     n_cfg.hold     = pwdata[CNT_W-1:0];
                default:      n_cfg          = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DEBOUNCE: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_cfg.debounce};
            REG_WINDOW:   prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_cfg.window};
            REG_HOLD:     prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_cfg.hold};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce <= DEBOUNCE_RST;
            r_cfg.window   <= WINDOW_RST;
            r_cfg.hold     <= HOLD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/bcc_timer.sv
// Loadable countdown timer with a running flag.
module bcc_timer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  bcc_pkg::t_tmr_cmd           i_cmd,
    input  logic [bcc_pkg::CNT_W-1:0]   i_load_val,
    output logic                        o_running,
    output logic                        o_expiring
);
    import bcc_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_run;
    logic             n_run;
    logic             w_le1;

    assign w_le1      = (r_cnt <= {{(CNT_W-1){1'b0}}, 1'b1});
    assign o_running  = r_run;
    assign o_expiring = r_run && w_le1;

    always_comb begin
        n_cnt = r_cnt;
        n_run = r_run;
        if (i_en) begin
            if (i_cmd.load) begin
                n_cnt = i_load_val;
                n_run = 1'b1;
            end else if (i_cmd.stop) begin
                n_cnt = '0;
                n_run = 1'b0;
            end else if (r_run) begin
                n_cnt = w_le1 ? '0 : r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_run <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_run <= n_run;
        end
    end

endmodule

FILE: rtl/bcc_core.sv
// Per-tick classification: debounce, double-click window and hold timers.
module bcc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_level,
    input  bcc_pkg::t_cfg     i_cfg,
    output bcc_pkg::t_events  o_events
);
    import bcc_pkg::*;

    logic r_last;
    logic n_last;
    logic r_pressed;
    logic n_pressed;
    logic r_await;
    logic n_await;

    logic     w_edge;
    logic     w_low;
    logic     w_win_run;
    logic     w_win_exp;
    logic     w_hold_run;
    logic     w_hold_exp;
    logic     w_deb_run;
    logic     w_deb_exp;
    logic     w_win_fire;
    logic     w_hold_fire;
    logic     w_deb_fire;
    logic     w_await_eff;
    logic     w_press_fire;
    logic     w_first;
    logic     w_dbl;
    logic     w_release;
    t_tmr_cmd w_win_cmd;
    t_tmr_cmd w_hold_cmd;
    t_tmr_cmd w_deb_cmd;

    assign w_edge       = (i_level != r_last);
    assign w_low        = !i_level;
    assign w_win_fire   = w_win_run && w_win_exp;
    assign w_hold_fire  = w_hold_run && w_hold_exp;
    assign w_deb_fire   = !w_edge && w_deb_run && w_deb_exp;
    assign w_await_eff  = w_win_fire ? 1'b0 : r_await;
    assign w_press_fire = w_deb_fire && w_low && !r_pressed;
    assign w_first      = w_press_fire && !w_await_eff;
    assign w_dbl        = w_press_fire && w_await_eff;
    assign w_release    = w_deb_fire && !w_low && r_pressed;

    assign w_win_cmd.load  = w_first;
    assign w_win_cmd.stop  = w_win_fire || w_dbl;
    assign w_hold_cmd.load = w_first || (w_hold_fire && w_low && !w_dbl);
    assign w_hold_cmd.stop = (w_hold_fire && !w_low) || w_dbl || w_release;
    assign w_deb_cmd.load  = w_edge;
    assign w_deb_cmd.stop  = w_deb_fire;

    assign o_events.press  = (w_hold_fire && w_low) || w_first;
    assign o_events.dbl    = w_dbl;
    assign o_events.single = w_win_fire && r_await;

    bcc_timer u_win_tmr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (i_en),
        .i_cmd      (w_win_cmd),
        .i_load_val (i_cfg.window),
        .o_running  (w_win_run),
        .o_expiring (w_win_exp)
    );

    bcc_timer u_hold_tmr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (i_en),
        .i_cmd      (w_hold_cmd),
        .i_load_val (i_cfg.hold),
        .o_running  (w_hold_run),
        .o_expiring (w_hold_exp)
    );

    bcc_timer u_deb_tmr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (i_en),
        .i_cmd      (w_deb_cmd),
        .i_load_val (i_cfg.debounce),
        .o_running  (w_deb_run),
        .o_expiring (w_deb_exp)
    );

    always_comb begin
        n_last    = r_last;
        n_pressed = r_pressed;
        n_await   = r_await;
        if (i_en) begin
            n_last  = i_level;
            n_await = w_await_eff;
            if (w_press_fire) begin
                n_pressed = 1'b1;
            end else if (w_release) begin
                n_pressed = 1'b0;
            end
            if (w_first) begin
                n_await = 1'b1;
            end else if (w_dbl) begin
                n_await = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= 1'b1;
            r_pressed <= 1'b0;
            r_await   <= 1'b0;
        end else begin
            r_last    <= n_last;
            r_pressed <= n_pressed;
            r_await   <= n_await;
        end
    end

endmodule

FILE: rtl/button_click_classifier_unit.sv
// Button click classifier: debounced press, double-click, single-click and hold repeat.
// One transaction carries the raw active-low button level of one time-base tick and
// yields exactly one result transaction with three event flags. A new tick is taken
// every clock cycle while the output side does not stall; a tick goes through an input
// register, one pass of timer and flag logic, and a result register. Timer lengths come
// from three 16-bit APB registers at byte addresses 0, 4 and 8 (debounce, double-click
// window, hold period); a new value takes effect the next time that timer is loaded.
module button_click_classifier_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_button_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_press_event,
    output logic                            o_double_click_event,
    output logic                            o_single_click_event,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bcc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bcc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bcc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bcc_pkg::*;

    logic    r_in_valid;
    logic    n_in_valid;
    logic    r_in_level;
    logic    n_in_level;
    logic    r_out_valid;
    logic    n_out_valid;
    t_events r_out_ev;
    t_events n_out_ev;
    t_events w_ev;
    t_cfg    w_cfg;
    logic    w_advance;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    bcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_level  (r_in_level),
        .i_cfg    (w_cfg),
        .o_events (w_ev)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_level  = r_in_level;
        n_out_valid = r_out_valid;
        n_out_ev    = r_out_ev;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
            n_in_level = i_button_level;
        end
        if (w_advance) begin
            n_out_valid = 1'b1;
            n_out_ev    = w_ev;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_level <= n_in_level;
        r_out_ev   <= n_out_ev;
    end

    assign o_out_valid          = r_out_valid;
    assign o_press_event        = r_out_ev.press;
    assign o_double_click_event = r_out_ev.dbl;
    assign o_single_click_event = r_out_ev.single;

endmodule

FILE: rtl/bcc_checker.sv
// Port-level checker of the button click classifier and its bind.
`include "button_click_classifier_unit_macros.svh"

module bcc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_press_event,
    input logic o_double_click_event,
    input logic o_single_click_event
);

    property p_ready_when_empty;
        !o_out_valid |-> o_in_ready;
    endproperty

    property p_no_dbl_and_single;
        o_out_valid |-> !(o_double_click_event && o_single_click_event);
    endproperty

    property p_stall_hold;
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_press_event)
            && $stable(o_double_click_event) && $stable(o_single_click_event);
    endproperty

    `BCC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")
    `BCC_ASSERT(a_ready_when_empty, i_clk, i_rst_n, p_ready_when_empty, "input stalled")
    `BCC_ASSERT(a_no_dbl_and_single, i_clk, i_rst_n, p_no_dbl_and_single, "double and single")
    `BCC_ASSERT(a_stall_hold, i_clk, i_rst_n, p_stall_hold, "stalled result changed")

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_in_ready           (o_in_ready),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_press_event        (o_press_event),
    .o_double_click_event (o_double_click_event),
    .o_single_click_event (o_single_click_event)
);
